// ----- src/strided_2d_convolution_defines.svh -----
// assertion macros for the strided convolution block
`ifndef STRIDED_2D_CONVOLUTION_DEFINES_SVH
`define STRIDED_2D_CONVOLUTION_DEFINES_SVH

// consequent must hold in the same cycle as the antecedent
`define SCONV_ASSERT_NOW(name, clk, rst_n, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("sconv check failed");

// consequent must hold in the cycle after the antecedent
`define SCONV_ASSERT_NEXT(name, clk, rst_n, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("sconv check failed");

`endif

// ----- src/sconv_pkg.sv -----
`default_nettype none

package sconv_pkg;

  // image and kernel limits
  localparam int MAX_WIDTH  = 32;
  localparam int MAX_HEIGHT = 1024;
  localparam int MAX_KERNEL = 3;
  localparam int MAX_STEP   = 4;

  // field widths
  localparam int PIX_W   = 8;
  localparam int ROW_W   = 11;
  localparam int COL_W   = 6;
  localparam int ADDR_W  = $clog2(MAX_WIDTH);
  localparam int SLOT_W  = 2;
  localparam int COEF_W  = 16;
  localparam int KROW_W  = 48;
  localparam int SUM_W   = 28;
  localparam int CIDX_W  = 3;

  // configuration register indexes
  typedef enum logic [CIDX_W-1:0] {
    REG_KERNEL_HEIGHT = 3'd0,
    REG_KERNEL_WIDTH  = 3'd1,
    REG_STEP_SIZE     = 3'd2,
    REG_ZERO_BORDER   = 3'd3,
    REG_IMAGE_WIDTH   = 3'd4,
    REG_KERNEL_ROW_0  = 3'd5,
    REG_KERNEL_ROW_1  = 3'd6,
    REG_KERNEL_ROW_2  = 3'd7
  } cfg_reg_e;

  // commands from the controller to the datapath
  typedef struct packed {
    logic start;
    logic advance;
    logic mac_start;
    logic push;
    logic flush;
  } dp_cmd_t;

  // status from the datapath to the controller
  typedef struct packed {
    logic walk_done;
    logic cand_ok;
    logic mac_busy;
    logic out_free;
    logic pend_valid;
  } dp_status_t;

endpackage

`default_nettype wire

// ----- src/strided_2d_convolution.sv -----
`default_nettype none
`include "strided_2d_convolution_defines.svh"

// Strided 2D correlation over a raster pixel stream, kernel up to 3x3 with
// signed Q8.8 coefficients, optional one-pixel zero border. Each input word
// is written into a three-row line store and then the windows it completes
// are walked one by one, each candidate window position in turn, with each
// window that is emitted going through a single multiply-accumulate unit
// reading the line store one tap a cycle. The word is accepted before its
// walk starts and its last result is handed over after the walk ends; the
// first pixel and the last pixel of a bordered image walk a whole border row,
// and a stalled output holds the walk.
// The output register lets the last result of one word wait while the next
// word is accepted. Configuration must only be written while idle.
module strided_2d_convolution (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          cfg_valid_i,
  output logic                               cfg_ready_o,
  input  wire logic [sconv_pkg::CIDX_W-1:0]  cfg_index_i,
  input  wire logic [sconv_pkg::KROW_W-1:0]  cfg_data_i,
  input  wire logic                          in_valid_i,
  output logic                               in_ready_o,
  input  wire logic [sconv_pkg::PIX_W-1:0]   pixel_i,
  input  wire logic                          image_end_i,
  output logic                               out_valid_o,
  input  wire logic                          out_ready_i,
  output logic signed [sconv_pkg::SUM_W-1:0] filtered_value_o,
  output logic [sconv_pkg::ROW_W-1:0]        out_row_o,
  output logic [sconv_pkg::COL_W-1:0]        out_col_o,
  output logic                               run_last_o
);
  import sconv_pkg::*;

  dp_cmd_t    cmd;
  dp_status_t status;

  assign cfg_ready_o = 1'b1;

  // sequencing
  sconv_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  // line store, window walk and arithmetic
  sconv_dp u_dp (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_valid_i      (cfg_valid_i),
    .cfg_index_i      (cfg_index_i),
    .cfg_data_i       (cfg_data_i),
    .pixel_i          (pixel_i),
    .image_end_i      (image_end_i),
    .cmd_i            (cmd),
    .status_o         (status),
    .out_ready_i      (out_ready_i),
    .out_valid_o      (out_valid_o),
    .filtered_value_o (filtered_value_o),
    .out_row_o        (out_row_o),
    .out_col_o        (out_col_o),
    .run_last_o       (run_last_o)
  );

  // checks
  `SCONV_ASSERT_NEXT(a_busy_after_word, clk_i, rst_ni, in_valid_i && in_ready_o, !in_ready_o)
  `SCONV_ASSERT_NOW(a_idle_no_pending, clk_i, rst_ni, in_ready_o, !status.pend_valid)
  `SCONV_ASSERT_NOW(a_mac_not_idle, clk_i, rst_ni, status.mac_busy, !in_ready_o)

endmodule

`default_nettype wire

// ----- src/sconv_ctrl.sv -----
`default_nettype none

module sconv_ctrl (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                in_valid_i,
  output logic                     in_ready_o,
  input  wire sconv_pkg::dp_status_t status_i,
  output sconv_pkg::dp_cmd_t       cmd_o
);
  import sconv_pkg::*;

  typedef enum logic [4:0] {
    ST_IDLE  = 5'b00001,
    ST_SCAN  = 5'b00010,
    ST_MAC   = 5'b00100,
    ST_PUSH  = 5'b01000,
    ST_FLUSH = 5'b10000
  } state_e;

  state_e state_q, state_d;

  // next state and commands
  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.start = 1'b1;
          state_d     = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (status_i.walk_done) begin
          state_d = status_i.pend_valid ? ST_FLUSH : ST_IDLE;
        end else if (status_i.cand_ok) begin
          cmd_o.mac_start = 1'b1;
          state_d         = ST_MAC;
        end else begin
          cmd_o.advance = 1'b1;
        end
      end
      ST_MAC: begin
        if (!status_i.mac_busy) begin
          state_d = ST_PUSH;
        end
      end
      ST_PUSH: begin
        if (!status_i.pend_valid || status_i.out_free) begin
          cmd_o.push    = 1'b1;
          cmd_o.advance = 1'b1;
          state_d       = ST_SCAN;
        end
      end
      ST_FLUSH: begin
        if (status_i.out_free) begin
          cmd_o.flush = 1'b1;
          state_d     = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // state register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

`default_nettype wire

// ----- src/sconv_dp.sv -----
`default_nettype none

module sconv_dp (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          cfg_valid_i,
  input  wire logic [sconv_pkg::CIDX_W-1:0]  cfg_index_i,
  input  wire logic [sconv_pkg::KROW_W-1:0]  cfg_data_i,
  input  wire logic [sconv_pkg::PIX_W-1:0]   pixel_i,
  input  wire logic                          image_end_i,
  input  wire sconv_pkg::dp_cmd_t            cmd_i,
  output sconv_pkg::dp_status_t              status_o,
  input  wire logic                          out_ready_i,
  output logic                               out_valid_o,
  output logic signed [sconv_pkg::SUM_W-1:0] filtered_value_o,
  output logic [sconv_pkg::ROW_W-1:0]        out_row_o,
  output logic [sconv_pkg::COL_W-1:0]        out_col_o,
  output logic                               run_last_o
);
  import sconv_pkg::*;

  // candidate walk phases, in emission order
  localparam logic [2:0] PH_INIT  = 3'd0;
  localparam logic [2:0] PH_TOP   = 3'd1;
  localparam logic [2:0] PH_LEFT  = 3'd2;
  localparam logic [2:0] PH_MAIN  = 3'd3;
  localparam logic [2:0] PH_RIGHT = 3'd4;
  localparam logic [2:0] PH_BOT   = 3'd5;
  localparam logic [2:0] PH_DONE  = 3'd6;

  typedef struct packed {
    logic [ROW_W-1:0] q;
    logic [1:0]       r;
  } divres_t;

  // quotient and remainder by the step size (1..4)
  function automatic divres_t div_step(input logic [ROW_W-1:0] x, input logic [2:0] s);
    divres_t             res;
    logic [2*ROW_W-1:0]  prod;
    logic [ROW_W-1:0]    back;
    res  = '0;
    prod = '0;
    back = '0;
    case (s)
      3'd2: begin
        res.q = x >> 1;
        res.r = {1'b0, x[0]};
      end
      3'd3: begin
        prod  = (2*ROW_W)'(x) * (2*ROW_W)'(683);
        res.q = ROW_W'(prod >> 11);
        back  = x - ROW_W'(res.q * ROW_W'(3));
        res.r = back[1:0];
      end
      3'd4: begin
        res.q = x >> 2;
        res.r = x[1:0];
      end
      default: begin
        res.q = x;
        res.r = 2'd0;
      end
    endcase
    return res;
  endfunction

  // configuration registers
  logic [1:0]        kh_q, kw_q;
  logic [2:0]        step_q;
  logic              border_q;
  logic [COL_W-1:0]  width_q;
  logic [KROW_W-1:0] krow_q [MAX_KERNEL];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      kh_q     <= 2'd3;
      kw_q     <= 2'd3;
      step_q   <= 3'd1;
      border_q <= 1'b0;
      width_q  <= COL_W'(MAX_WIDTH);
      for (int i = 0; i < MAX_KERNEL; i++) begin
        krow_q[i] <= '0;
      end
    end else if (cfg_valid_i) begin
      case (cfg_reg_e'(cfg_index_i))
        REG_KERNEL_HEIGHT: kh_q     <= cfg_data_i[1:0];
        REG_KERNEL_WIDTH:  kw_q     <= cfg_data_i[1:0];
        REG_STEP_SIZE:     step_q   <= cfg_data_i[2:0];
        REG_ZERO_BORDER:   border_q <= cfg_data_i[0];
        REG_IMAGE_WIDTH:   width_q  <= cfg_data_i[COL_W-1:0];
        REG_KERNEL_ROW_0:  krow_q[0] <= cfg_data_i;
        REG_KERNEL_ROW_1:  krow_q[1] <= cfg_data_i;
        REG_KERNEL_ROW_2:  krow_q[2] <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // clamped configuration
  logic [1:0]       kh, kw;
  logic [2:0]       stp;
  logic [COL_W-1:0] wid, wid_m1, pw;

  always_comb begin
    kh  = (kh_q == 2'd0) ? 2'd1 : kh_q;
    kw  = (kw_q == 2'd0) ? 2'd1 : kw_q;
    stp = (step_q == 3'd0) ? 3'd1 :
          (step_q > 3'(MAX_STEP)) ? 3'(MAX_STEP) : step_q;
    wid = (width_q == '0) ? COL_W'(1) :
          (width_q > COL_W'(MAX_WIDTH)) ? COL_W'(MAX_WIDTH) : width_q;
    wid_m1 = wid - COL_W'(1);
    pw     = wid + {{(COL_W-2){1'b0}}, border_q, 1'b0};
  end

  // position counters
  logic [COL_W-1:0]  col_cnt_q, col_cl;
  logic [ROW_W-1:0]  row_cnt_q;
  logic [SLOT_W-1:0] slot_q;
  logic              drop, rowend;

  assign col_cl = (col_cnt_q > wid_m1) ? wid_m1 : col_cnt_q;
  assign drop   = row_cnt_q >= ROW_W'(MAX_HEIGHT);
  assign rowend = col_cl == wid_m1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_cnt_q <= '0;
      row_cnt_q <= '0;
      slot_q    <= '0;
    end else if (cmd_i.start) begin
      if (image_end_i) begin
        col_cnt_q <= '0;
        row_cnt_q <= '0;
        slot_q    <= '0;
      end else if (rowend) begin
        col_cnt_q <= '0;
        row_cnt_q <= drop ? ROW_W'(MAX_HEIGHT) : row_cnt_q + ROW_W'(1);
        // slot stays on the last stored row once rows are dropped
        if (!drop && row_cnt_q != ROW_W'(MAX_HEIGHT - 1)) begin
          slot_q <= (slot_q == SLOT_W'(MAX_KERNEL - 1)) ? '0 : slot_q + SLOT_W'(1);
        end
      end else begin
        col_cnt_q <= col_cl + COL_W'(1);
      end
    end
  end

  // word being worked on
  logic [COL_W-1:0]  cur_col_q;
  logic [ROW_W-1:0]  cur_row_q;
  logic [SLOT_W-1:0] cur_slot_q;
  logic              drop_q, rowend_q, end_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_col_q  <= '0;
      cur_row_q  <= '0;
      cur_slot_q <= '0;
      drop_q     <= 1'b0;
      rowend_q   <= 1'b0;
      end_q      <= 1'b0;
    end else if (cmd_i.start) begin
      cur_col_q  <= col_cl;
      cur_row_q  <= row_cnt_q;
      cur_slot_q <= slot_q;
      drop_q     <= drop;
      rowend_q   <= rowend;
      end_q      <= image_end_i;
    end
  end

  // phases that apply to this word
  logic [PH_BOT:PH_TOP] ph_en;

  always_comb begin
    ph_en[PH_TOP]   = !drop_q && border_q && cur_row_q == '0 && cur_col_q == '0;
    ph_en[PH_LEFT]  = !drop_q && border_q && cur_col_q == '0;
    ph_en[PH_MAIN]  = !drop_q;
    ph_en[PH_RIGHT] = !drop_q && border_q && rowend_q;
    ph_en[PH_BOT]   = end_q && border_q && (rowend_q || drop_q);
  end

  // candidate walker
  logic [2:0]       phase_q, phase_next;
  logic [COL_W-1:0] pc_q;

  always_comb begin
    phase_next = PH_DONE;
    for (int i = PH_BOT; i >= PH_TOP; i--) begin
      if (3'(i) > phase_q && ph_en[i]) begin
        phase_next = 3'(i);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_DONE;
      pc_q    <= '0;
    end else if (cmd_i.start) begin
      phase_q <= PH_INIT;
      pc_q    <= '0;
    end else if (cmd_i.advance) begin
      if ((phase_q == PH_TOP || phase_q == PH_BOT) && pc_q != pw - COL_W'(1)) begin
        pc_q <= pc_q + COL_W'(1);
      end else begin
        phase_q <= phase_next;
        pc_q    <= '0;
      end
    end
  end

  // candidate window, given by its bottom-right corner
  logic [ROW_W:0]   lr, pr;
  logic [COL_W-1:0] pc;
  logic [12:0]      r0;
  logic [7:0]       c0;
  divres_t          rdiv, cdiv;
  logic             cand_ok;

  always_comb begin
    lr = drop_q ? (ROW_W+1)'(MAX_HEIGHT - 1) : {1'b0, cur_row_q};
    case (phase_q)
      PH_TOP: begin
        pr = '0;
        pc = pc_q;
      end
      PH_LEFT: begin
        pr = {1'b0, cur_row_q} + (ROW_W+1)'(border_q);
        pc = '0;
      end
      PH_MAIN: begin
        pr = {1'b0, cur_row_q} + (ROW_W+1)'(border_q);
        pc = cur_col_q + COL_W'(border_q);
      end
      PH_RIGHT: begin
        pr = {1'b0, cur_row_q} + (ROW_W+1)'(border_q);
        pc = pw - COL_W'(1);
      end
      PH_BOT: begin
        pr = lr + (ROW_W+1)'(2);
        pc = pc_q;
      end
      default: begin
        pr = '0;
        pc = '0;
      end
    endcase
    r0      = 13'(pr) - 13'(kh) + 13'd1;
    c0      = 8'(pc) - 8'(kw) + 8'd1;
    rdiv    = div_step(r0[ROW_W-1:0], stp);
    cdiv    = div_step(ROW_W'(c0[COL_W-1:0]), stp);
    cand_ok = phase_q >= PH_TOP && phase_q <= PH_BOT && !r0[12] && !c0[7] &&
              rdiv.r == 2'd0 && cdiv.r == 2'd0;
  end

  // tap sequencer
  logic [ROW_W-1:0] r0_q, qrow_q;
  logic [COL_W-1:0] c0_q, qcol_q;
  logic [1:0]       k_q, l_q;
  logic             issue_q, s1_v_q, s2_v_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      k_q     <= '0;
      l_q     <= '0;
      issue_q <= 1'b0;
      s1_v_q  <= 1'b0;
      s2_v_q  <= 1'b0;
    end else begin
      s1_v_q <= issue_q;
      s2_v_q <= s1_v_q;
      if (cmd_i.mac_start) begin
        k_q     <= '0;
        l_q     <= '0;
        issue_q <= 1'b1;
      end else if (issue_q) begin
        if (l_q == kw - 2'd1) begin
          l_q <= '0;
          if (k_q == kh - 2'd1) begin
            issue_q <= 1'b0;
          end else begin
            k_q <= k_q + 2'd1;
          end
        end else begin
          l_q <= l_q + 2'd1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.mac_start) begin
      r0_q   <= r0[ROW_W-1:0];
      c0_q   <= c0[COL_W-1:0];
      qrow_q <= rdiv.q;
      qcol_q <= cdiv.q[COL_W-1:0];
    end
  end

  // tap address into the line store
  logic [12:0]       ty, td;
  logic [7:0]        tx;
  logic              tap_ok;
  logic [2:0]        slot_t;
  logic [SLOT_W-1:0] rd_slot;

  always_comb begin
    ty      = 13'(r0_q) + 13'(k_q) - 13'(border_q);
    tx      = 8'(c0_q) + 8'(l_q) - 8'(border_q);
    td      = 13'(lr) - ty;
    tap_ok  = !ty[12] && !tx[7] && tx < 8'(wid) && !td[12] && td <= 13'(MAX_KERNEL - 1);
    slot_t  = 3'(cur_slot_q) + 3'(MAX_KERNEL) - 3'(td[1:0]);
    rd_slot = (slot_t >= 3'(MAX_KERNEL)) ? SLOT_W'(slot_t - 3'(MAX_KERNEL)) :
                                           SLOT_W'(slot_t);
  end

  // line store, one row per slot
  logic [PIX_W-1:0] line_mem [MAX_KERNEL][MAX_WIDTH];
  logic [PIX_W-1:0] rd_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.start && !drop) begin
      line_mem[slot_q][col_cl[ADDR_W-1:0]] <= pixel_i;
    end
    rd_q <= line_mem[rd_slot][tx[ADDR_W-1:0]];
  end

  // multiply and accumulate
  logic signed [COEF_W-1:0]         coef_q;
  logic                             zero_q;
  logic signed [PIX_W:0]            pix_s;
  logic signed [COEF_W+PIX_W:0]     prod_q;
  logic signed [SUM_W-1:0]          acc_q;

  assign pix_s = zero_q ? '0 : $signed({1'b0, rd_q});

  always_ff @(posedge clk_i) begin
    coef_q <= krow_q[k_q][{l_q, 4'b0000} +: COEF_W];
    zero_q <= !tap_ok;
    prod_q <= coef_q * pix_s;
    if (cmd_i.mac_start) begin
      acc_q <= '0;
    end else if (s2_v_q) begin
      acc_q <= acc_q + SUM_W'(prod_q);
    end
  end

  // pending result and output register
  logic                    pend_v_q, out_v_q;
  logic signed [SUM_W-1:0] pend_val_q;
  logic [ROW_W-1:0]        pend_row_q;
  logic [COL_W-1:0]        pend_col_q;
  logic                    out_free, load_out;

  assign out_free = !out_v_q || out_ready_i;
  assign load_out = (cmd_i.push && pend_v_q) || cmd_i.flush;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_v_q <= 1'b0;
      out_v_q  <= 1'b0;
    end else begin
      if (cmd_i.push) begin
        pend_v_q <= 1'b1;
      end else if (cmd_i.flush) begin
        pend_v_q <= 1'b0;
      end
      if (load_out) begin
        out_v_q <= 1'b1;
      end else if (out_ready_i) begin
        out_v_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.push) begin
      pend_val_q <= acc_q;
      pend_row_q <= qrow_q;
      pend_col_q <= qcol_q;
    end
    if (load_out) begin
      filtered_value_o <= pend_val_q;
      out_row_o        <= pend_row_q;
      out_col_o        <= pend_col_q;
      run_last_o       <= cmd_i.flush && end_q;
    end
  end

  assign out_valid_o = out_v_q;

  // status to the controller
  always_comb begin
    status_o.walk_done  = phase_q == PH_DONE;
    status_o.cand_ok    = cand_ok;
    status_o.mac_busy   = issue_q || s1_v_q || s2_v_q;
    status_o.out_free   = out_free;
    status_o.pend_valid = pend_v_q;
  end

endmodule

`default_nettype wire
